// ===== rtl/core/wildcard_byte_pattern_scanner_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: assertion macros
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wbps assertion failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wbps assertion failed");

`endif

// ===== rtl/core/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Constants and codes for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int POS_W       = 6;                        // pattern slot field
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);  // holds 1..PATTERN_MAX
  localparam int BYTE_W      = 8;
  localparam int OFFSET_W    = 32;
  localparam int OCC_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WILDCARD = 2'd0,
    REG_PAT_LEN  = 2'd1,
    REG_MATCH_OCC = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_SCAN = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_FOUND = 1'b0,
    STATUS_MISS  = 1'b1
  } status_t;

endpackage

// ===== rtl/core/wildcard_byte_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Streams bytes through a window and reports the Nth wildcard pattern match.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat per byte. in_func = load writes
//   in_byte_value into pattern slot in_pattern_position; in_func = scan
//   shifts a data byte into the window, in_region_end marking the region's
//   last byte. Result channel (out_*): at most one beat per input beat,
//   either found with the window start offset, or not found with offset 0.
//   Configuration (cfg_*): wildcard value, pattern length, occurrence index;
//   write only while no beat is in flight.
// Path: an accepted beat is held in the input register, and its result is
//   loaded into the output register when the input register drains.
// Throughput: one beat per cycle unless a held output beat stalls; the full
//   window compare sits between the input register and the output register.
// Reset: counters clear, wildcard 0, length 1, occurrence 0. Pattern slots
//   are undefined until loaded.
// Stall: a held output beat stops the input register from draining; in_stall
//   rises only when the input register is full and cannot move on.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [wbps_pkg::POS_W-1:0]      in_pattern_position,
  input  logic [wbps_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic                            in_region_end,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [wbps_pkg::OFFSET_W-1:0]   out_match_offset,
  // configuration
  input  logic                            cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PMAX = wbps_pkg::PATTERN_MAX;
  localparam int BW   = wbps_pkg::BYTE_W;
  localparam int LW   = wbps_pkg::LEN_W;
  localparam int OW   = wbps_pkg::OFFSET_W;
  localparam int QW   = wbps_pkg::OCC_W;
  localparam int IW   = $clog2(PMAX);

  // configuration registers
  logic [BW-1:0] wildcard_r;
  logic [LW-1:0] pat_len_r;     // already clamped to 1..PMAX
  logic [QW-1:0] match_occ_r;

  // input register
  logic                          s1_valid_r;
  logic                          s1_func_r;
  logic [wbps_pkg::POS_W-1:0]    s1_pos_r;
  logic [BW-1:0]                 s1_byte_r;
  logic                          s1_last_r;

  // scan state
  logic [BW-1:0] pattern_r [PMAX];
  logic [BW-1:0] window_r  [PMAX];   // newest byte at index 0
  logic [OW-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [QW-1:0] matches_seen_r, matches_seen_nxt;
  logic          reported_r, reported_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [OW-1:0] out_offset_r, out_offset_nxt;

  logic advance, in_accept, s1_fire, scan_fire, load_fire;
  logic [LW-1:0]      cfg_len_clamped;
  logic [BW-1:0]      win_new [PMAX];
  logic [PMAX*BW-1:0] rev_win, aligned;
  logic [LW-1:0]      shift_amt;
  logic [PMAX-1:0]    lane_ok;
  logic [OW-1:0]      bytes_inc;
  logic               window_full, hit, found, not_found;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && advance;
  assign scan_fire = s1_fire && (s1_func_r == wbps_pkg::FUNC_SCAN);
  assign load_fire = s1_fire && (s1_func_r == wbps_pkg::FUNC_LOAD);

  // length register: only the low LW bits count; 0 acts as 1, values above the store size saturate
  always_comb begin
    if (cfg_wdata[LW-1:0] == '0) begin
      cfg_len_clamped = LW'(1);
    end else if (cfg_wdata[LW-1:0] > LW'(PMAX)) begin
      cfg_len_clamped = LW'(PMAX);
    end else begin
      cfg_len_clamped = cfg_wdata[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wildcard_r  <= '0;
      pat_len_r   <= LW'(1);
      match_occ_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_WILDCARD:  wildcard_r  <= cfg_wdata[BW-1:0];
        wbps_pkg::REG_PAT_LEN:   pat_len_r   <= cfg_len_clamped;
        wbps_pkg::REG_MATCH_OCC: match_occ_r <= cfg_wdata[QW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= in_func;
      s1_pos_r  <= in_pattern_position;
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_region_end;
    end
  end

  // window with the current byte shifted in
  always_comb begin
    win_new[0] = s1_byte_r;
    for (int i = 1; i < PMAX; i++) begin
      win_new[i] = window_r[i-1];
    end
  end

  // Lane j must see the byte of age len-1-j. Reverse the window so that
  // the oldest slot is at the bottom, then shift right by PMAX-len bytes.
  always_comb begin
    for (int i = 0; i < PMAX; i++) begin
      rev_win[i*BW +: BW] = win_new[PMAX-1-i];
    end
  end

  assign shift_amt = LW'(PMAX) - pat_len_r;
  assign aligned   = rev_win >> {shift_amt, 3'b000};

  always_comb begin
    for (int j = 0; j < PMAX; j++) begin
      lane_ok[j] = (LW'(j) >= pat_len_r) || (pattern_r[j] == wildcard_r) ||
                   (pattern_r[j] == aligned[j*BW +: BW]);
    end
  end

  assign bytes_inc   = (bytes_seen_r == '1) ? bytes_seen_r : bytes_seen_r + OW'(1);
  assign window_full = bytes_inc >= OW'(pat_len_r);
  assign hit         = (&lane_ok) && window_full && !reported_r;
  assign found       = hit && (matches_seen_r == match_occ_r);
  assign not_found   = s1_last_r && !reported_r && !found;

  // counters and output register
  always_comb begin
    bytes_seen_nxt   = bytes_seen_r;
    matches_seen_nxt = matches_seen_r;
    reported_nxt     = reported_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_offset_nxt   = out_offset_r;
    if (advance) begin
      out_valid_nxt = 1'b0;
    end
    if (scan_fire) begin
      bytes_seen_nxt = bytes_inc;
      if (found) begin
        reported_nxt   = 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = wbps_pkg::STATUS_FOUND;
        out_offset_nxt = bytes_inc - OW'(pat_len_r);
      end else if (hit && (matches_seen_r != '1)) begin
        matches_seen_nxt = matches_seen_r + QW'(1);
      end
      if (not_found) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = wbps_pkg::STATUS_MISS;
        out_offset_nxt = '0;
      end
      if (s1_last_r) begin
        // rearm for the next region
        bytes_seen_nxt   = '0;
        matches_seen_nxt = '0;
        reported_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r   <= '0;
      matches_seen_r <= '0;
      reported_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      bytes_seen_r   <= bytes_seen_nxt;
      matches_seen_r <= matches_seen_nxt;
      reported_r     <= reported_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  // Only slots below the length are compared, and only once that many bytes
  // arrived in the region, so stale window contents need no clearing.
  always_ff @(posedge clk) begin
    if (scan_fire) begin
      for (int i = 0; i < PMAX; i++) begin
        window_r[i] <= win_new[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire && (int'(s1_pos_r) < PMAX)) begin
      pattern_r[s1_pos_r[IW-1:0]] <= s1_byte_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_offset = out_offset_r;

`include "wildcard_byte_pattern_scanner_unit_defines.svh"

  `WBPS_ASSERT_NEXT(a_quiet_after_report, scan_fire && reported_r && !s1_last_r, !out_valid_r)
  `WBPS_ASSERT_NEXT(a_rearm_on_last, scan_fire && s1_last_r,
                    (bytes_seen_r == '0) && (matches_seen_r == '0) && !reported_r)
  `WBPS_ASSERT_NEXT(a_found_marks_reported, scan_fire && found && !s1_last_r, reported_r)
  `WBPS_ASSERT_NOW(a_not_found_zero_offset,
                   out_valid_r && (out_status_r == wbps_pkg::STATUS_MISS), out_offset_r == '0)

endmodule
